@@ hdl/fhri_pkg.sv @@
// fhri_pkg: shared types, constants and the hash step for the hashed record index
// used by fhri_hasher, fhri_queue, fhri_inserter and the top level
// no dependencies
package fhri_pkg;

    // fnv-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] EMPTY_KEY = 64'h0;

    // field widths
    localparam int HASH_W   = 64;
    localparam int BYTE_W   = 8;
    localparam int SLOT_O_W = 12;
    localparam int OFFS_W   = 32;
    localparam int RECB_W   = 16;
    localparam int MTDATA_W = 112;

    // configuration reset value and default table depth
    localparam logic [RECB_W-1:0] RECORD_BYTES_RESET = 16'd144;
    localparam int TABLE_DEPTH_DEFAULT = 4096;

    // hash queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one finished record hash with its valid flag
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } hash_word_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MOD,
        B_LOOKUP,
        B_CHECK,
        B_EMIT
    } back_state_t;

    // one fnv-1a round: xor the byte, multiply by the prime modulo 2^64
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return x * FNV_PRIME;
    endfunction

endpackage

@@ hdl/fnv1a_hashed_record_index.sv @@
// fnv1a_hashed_record_index: top level of the hashed record index
// depends on fhri_pkg, fhri_hasher, fhri_queue, fhri_inserter
//
// Usage: payload bytes arrive on the s_ stream, one word per byte, s_tlast on
// the final byte of a record. Each byte is folded into a 64-bit FNV-1a hash.
// The finished hash goes into a two-entry queue; the back end then finds the
// home slot (low hash bits, or a bit-serial remainder sequence when
// TABLE_DEPTH is not a power of two), probes the key memory one slot per cycle
// with wrap, inserts hash and journal offset and sends one m_ word per record.
// A full table costs TABLE_DEPTH probes and sets m_tuser. Sustained rate is
// one byte per cycle while the queue has room, the record rate is bounded by
// the probe loop on the single memory read port.
// After reset the key memory is cleared with s_tready low; cfg writes are
// taken at any time, record_bytes resets to 144.
// When m_tready is low the result waits in the output register; hashing goes on
// until the queue fills, then s_tready drops.
module fnv1a_hashed_record_index
    import fhri_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input byte stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] payload_byte
    input  logic                s_tlast,   // last_byte
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MTDATA_W-1:0] m_tdata,   // [63:0] hash_value, [75:64] slot_index,
                                           // [107:76] record_offset, [111:108] zero
    output logic                m_tuser,   // [0] table_full
    // record_bytes register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RECB_W-1:0]   cfg_data
);

    hash_word_t          push, head;
    logic                queue_full, pop, table_ready;
    logic [HASH_W-1:0]   m_hash;
    logic [SLOT_O_W-1:0] m_slot;
    logic [OFFS_W-1:0]   m_offset;

    // front end hashing
    fhri_hasher u_hasher (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .table_ready (table_ready),
        .queue_full  (queue_full),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .byte_in     (s_tdata),
        .last_in     (s_tlast),
        .push        (push)
    );

    // hash queue
    fhri_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .head    (head),
        .pop     (pop)
    );

    // back end insert
    fhri_inserter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_inserter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .table_ready (table_ready),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_hash      (m_hash),
        .m_slot      (m_slot),
        .m_offset    (m_offset),
        .m_full      (m_tuser)
    );

    // result word packing
    assign m_tdata = {{(MTDATA_W-HASH_W-SLOT_O_W-OFFS_W){1'b0}}, m_offset, m_slot, m_hash};

endmodule

@@ hdl/fhri_hasher.sv @@
// fhri_hasher: front end, folds one payload byte per cycle, while s_tready is high, into the running hash
// pushes the finished hash into the queue on the last byte of a record
// depends on fhri_pkg
module fhri_hasher
    import fhri_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              table_ready,
    input  logic              queue_full,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              last_in,
    output hash_word_t        push
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] folded;
    logic              accept;

    // take a word unless the table is still clearing or the queue is full
    assign s_tready = table_ready && !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign folded   = fnv_step(hash_reg, byte_in);

    // next running hash and queue push
    always_comb begin
        hash_next = hash_reg;
        push.valid = 1'b0;
        push.hash  = folded;
        if (accept) begin
            if (last_in) begin
                push.valid = 1'b1;
                hash_next  = FNV_BASIS;
            end else begin
                hash_next = folded;
            end
        end
    end

    // running hash register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= FNV_BASIS;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

@@ hdl/fhri_queue.sv @@
// fhri_queue: short queue of finished record hashes between front and back
// depends on fhri_pkg
module fhri_queue
    import fhri_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  hash_word_t push,
    output logic       full,
    output hash_word_t head,
    input  logic       pop
);

    logic [HASH_W-1:0] store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.hash  = store_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push.hash;
        end
    end

endmodule

@@ hdl/fhri_inserter.sv @@
// fhri_inserter: back end, finds the home slot, probes the key table linearly,
// inserts into a free slot and presents the result word; holds key and offset memories
// depends on fhri_pkg
module fhri_inserter
    import fhri_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RECB_W-1:0]   cfg_data,
    output logic                table_ready,
    input  hash_word_t          head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [HASH_W-1:0]   m_hash,
    output logic [SLOT_O_W-1:0] m_slot,
    output logic [OFFS_W-1:0]   m_offset,
    output logic                m_full
);

    localparam int  SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int  TRY_W   = SLOT_W + 1;
    localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [TRY_W-1:0]  DEPTH_T   = TRY_W'(TABLE_DEPTH);

    // key and offset memories
    logic [HASH_W-1:0] key_mem [TABLE_DEPTH];
    logic [OFFS_W-1:0] off_mem [TABLE_DEPTH];

    back_state_t       state_reg, state_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [SLOT_W-1:0] slot_reg, slot_next, slot_inc;
    logic [TRY_W-1:0]  tries_reg, tries_next;
    logic [TRY_W-1:0]  rem_reg, rem_next, rem_shift;
    logic [5:0]        bit_reg, bit_next;
    logic              full_reg, full_next;
    logic [TRY_W-1:0]  entry_count_reg, entry_count_next;
    logic [OFFS_W-1:0] next_offset_reg, next_offset_next;
    logic [RECB_W-1:0] record_bytes_reg;
    logic              load_out;
    logic              m_valid_reg, m_valid_next;

    logic              key_we, off_we;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    logic [HASH_W-1:0] mem_wkey;
    logic [HASH_W-1:0] rd_key_reg;

    assign cfg_ready   = 1'b1;
    assign table_ready = (state_reg != B_CLEAR);
    assign m_tvalid    = m_valid_reg;
    assign slot_inc    = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign rem_shift   = {rem_reg[SLOT_W-1:0], hash_reg[bit_reg]};

    // sequencer: clear, home slot, probe, insert, emit
    always_comb begin
        state_next       = state_reg;
        hash_next        = hash_reg;
        slot_next        = slot_reg;
        tries_next       = tries_reg;
        rem_next         = rem_reg;
        bit_next         = bit_reg;
        full_next        = full_reg;
        entry_count_next = entry_count_reg;
        next_offset_next = next_offset_reg;
        pop              = 1'b0;
        load_out         = 1'b0;
        key_we           = 1'b0;
        off_we           = 1'b0;
        mem_waddr        = slot_reg;
        mem_wkey         = hash_reg;
        mem_raddr        = slot_reg;
        unique case (state_reg)
            B_CLEAR: begin
                key_we   = 1'b1;
                mem_wkey = EMPTY_KEY;
                if (slot_reg == LAST_SLOT) begin
                    slot_next  = '0;
                    state_next = B_IDLE;
                end else begin
                    slot_next = slot_inc;
                end
            end
            B_IDLE: begin
                if (head.valid) begin
                    pop       = 1'b1;
                    hash_next = head.hash;
                    if (IS_POW2) begin
                        slot_next  = head.hash[SLOT_W-1:0];
                        state_next = B_LOOKUP;
                    end else begin
                        rem_next   = '0;
                        bit_next   = 6'(HASH_W - 1);
                        state_next = B_MOD;
                    end
                end
            end
            B_MOD: begin
                // one remainder bit per cycle, msb first
                if (rem_shift >= DEPTH_T) begin
                    rem_next = rem_shift - DEPTH_T;
                end else begin
                    rem_next = rem_shift;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    slot_next  = rem_next[SLOT_W-1:0];
                    state_next = B_LOOKUP;
                end
            end
            B_LOOKUP: begin
                mem_raddr  = slot_reg;
                tries_next = '0;
                state_next = B_CHECK;
            end
            B_CHECK: begin
                // key of slot_reg is in rd_key_reg, next slot read is issued here
                mem_raddr = slot_inc;
                if (rd_key_reg == EMPTY_KEY) begin
                    key_we    = 1'b1;
                    off_we    = 1'b1;
                    full_next = 1'b0;
                    if (entry_count_reg != DEPTH_T) begin
                        entry_count_next = entry_count_reg + 1'b1;
                    end
                    state_next = B_EMIT;
                end else if (tries_reg == DEPTH_T - 1'b1) begin
                    full_next  = 1'b1;
                    state_next = B_EMIT;
                end else begin
                    slot_next  = slot_inc;
                    tries_next = tries_reg + 1'b1;
                end
            end
            B_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out         = 1'b1;
                    next_offset_next = next_offset_reg + {{(OFFS_W-RECB_W){1'b0}},
                                                          record_bytes_reg};
                    state_next       = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // output word valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= B_CLEAR;
            slot_reg         <= '0;
            tries_reg        <= '0;
            bit_reg          <= '0;
            entry_count_reg  <= '0;
            next_offset_reg  <= '0;
            record_bytes_reg <= RECORD_BYTES_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            tries_reg       <= tries_next;
            bit_reg         <= bit_next;
            entry_count_reg <= entry_count_next;
            next_offset_reg <= next_offset_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                record_bytes_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        full_reg <= full_next;
        if (load_out) begin
            m_hash   <= hash_reg;
            m_slot   <= full_reg ? '0 : SLOT_O_W'(slot_reg);
            m_offset <= next_offset_reg;
            m_full   <= full_reg;
        end
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[mem_waddr] <= mem_wkey;
        end
        rd_key_reg <= key_mem[mem_raddr];
    end

    // offset memory, written with each insert
    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[mem_waddr] <= next_offset_reg;
        end
    end

endmodule
